@@ hdl/sm3_pkg.sv @@
// sm3_pkg: shared types, constants and bit functions for the sm3 hash engine
// no dependencies; used by the controller, datapath and top level

package sm3_pkg;

    // initial chaining value
    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // round constants; the high one enters at round 16 already rotated by 16
    localparam logic [31:0] T_LOW       = 32'h79CC4519;
    localparam logic [31:0] T_HIGH      = 32'h7A879D8A;
    localparam logic [31:0] T_HIGH_ROT  = {T_HIGH[15:0], T_HIGH[31:16]};
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [31:0] PAD_MARK    = {PAD_BYTE, 24'h000000};

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_DONE
    } t_state;

    // source of the word shifted into the block window while padding
    typedef enum logic [2:0] {
        PAD_ZERO,
        PAD_LAST,
        PAD_MARK_WORD,
        PAD_LEN_HI,
        PAD_LEN_LO
    } t_pad_sel;

    typedef struct packed {
        logic       shift_in;   // message word enters the window, length += 32
        logic       pad_shift;  // padding word enters the window
        t_pad_sel   pad_sel;
        logic       latch_last; // hold the masked last word, add its bits
        logic [2:0] byte_n;     // saturated byte count of the last word
        logic       load;       // working registers take the chaining value
        logic       round;      // one compression round
        logic       early;      // rounds 0 to 15
        logic       t_switch;   // round 15: switch to the high constant
        logic       round_last; // round 63: fold into the chaining value
        logic       capture;    // digest out, chaining value back to iv
    } t_dp_cmd;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
        rotl32 = (x << r) | (x >> (6'd32 - {1'b0, r}));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

@@ hdl/sm3_if.sv @@
// sm3_if: valid/ready channel interfaces for message words and digests
// no dependencies

interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        is_last;

    modport source (output valid, data_word, byte_count, is_last, input ready);
    modport sink   (input valid, data_word, byte_count, is_last, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part_0;
    logic [63:0] digest_part_1;
    logic [63:0] digest_part_2;
    logic [63:0] digest_part_3;

    modport source (output valid, digest_part_0, digest_part_1, digest_part_2,
                    digest_part_3, input ready);
    modport sink   (input valid, digest_part_0, digest_part_1, digest_part_2,
                    digest_part_3, output ready);
endinterface

@@ hdl/sm3_ctrl.sv @@
// sm3_ctrl: sequencer for word intake, padding, 64 rounds and digest hand-off
// depends on sm3_pkg

module sm3_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_is_last,
    input  logic [2:0]          i_byte_count,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sm3_pkg::t_dp_cmd    o_cmd
);

    sm3_pkg::t_state r_state, n_state;
    logic [3:0] r_fill, n_fill;
    logic [4:0] r_pos, n_pos;
    logic [5:0] r_round, n_round;
    logic       r_pad, n_pad;
    logic       r_final, n_final;
    logic       r_two, n_two;
    logic       r_n_full, n_n_full;
    logic       r_out_valid, n_out_valid;

    logic [2:0] n_sat;
    logic [6:0] rem_bytes;
    logic [4:0] last_pos;
    logic [4:0] fill_pos;
    sm3_pkg::t_dp_cmd cmd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sm3_pkg::S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_round     <= '0;
            r_pad       <= 1'b0;
            r_final     <= 1'b0;
            r_two       <= 1'b0;
            r_n_full    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_round     <= n_round;
            r_pad       <= n_pad;
            r_final     <= n_final;
            r_two       <= n_two;
            r_n_full    <= n_n_full;
            r_out_valid <= n_out_valid;
        end
    end

    // byte count of the last word and the one-or-two block decision
    assign n_sat     = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign rem_bytes = {1'b0, r_fill, 2'b00} + {4'b0000, n_sat};
    assign last_pos  = r_two ? 5'd31 : 5'd15;
    assign fill_pos  = {1'b0, r_fill};

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_round     = r_round;
        n_pad       = r_pad;
        n_final     = r_final;
        n_two       = r_two;
        n_n_full    = r_n_full;
        o_in_ready  = 1'b0;
        cmd         = '0;
        cmd.pad_sel = sm3_pkg::PAD_ZERO;
        cmd.byte_n  = n_sat;

        case (r_state)
            sm3_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_is_last) begin
                        cmd.shift_in = 1'b1;
                        if (r_fill == 4'd15) begin
                            cmd.load = 1'b1;
                            n_fill   = '0;
                            n_round  = '0;
                            n_state  = sm3_pkg::S_ROUND;
                        end else begin
                            n_fill = r_fill + 4'd1;
                        end
                    end else begin
                        cmd.latch_last = 1'b1;
                        n_pad    = 1'b1;
                        n_n_full = (n_sat == 3'd4);
                        n_two    = (rem_bytes > 7'd55);
                        n_pos    = {1'b0, r_fill};
                        n_state  = sm3_pkg::S_PAD;
                    end
                end
            end

            sm3_pkg::S_PAD: begin
                cmd.pad_shift = 1'b1;
                if (r_pos == fill_pos) begin
                    cmd.pad_sel = sm3_pkg::PAD_LAST;
                end else if (r_n_full && (r_pos == fill_pos + 5'd1)) begin
                    cmd.pad_sel = sm3_pkg::PAD_MARK_WORD;
                end else if (r_pos == last_pos - 5'd1) begin
                    cmd.pad_sel = sm3_pkg::PAD_LEN_HI;
                end else if (r_pos == last_pos) begin
                    cmd.pad_sel = sm3_pkg::PAD_LEN_LO;
                end
                n_pos = r_pos + 5'd1;
                if (r_pos[3:0] == 4'd15) begin
                    cmd.load = 1'b1;
                    n_round  = '0;
                    n_final  = (r_pos == last_pos);
                    n_state  = sm3_pkg::S_ROUND;
                end
            end

            sm3_pkg::S_ROUND: begin
                cmd.round    = 1'b1;
                cmd.early    = (r_round[5:4] == 2'b00);
                cmd.t_switch = (r_round == 6'd15);
                n_round      = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    cmd.round_last = 1'b1;
                    if (!r_pad) begin
                        n_state = sm3_pkg::S_IDLE;
                    end else if (r_final) begin
                        n_state = sm3_pkg::S_DONE;
                    end else begin
                        n_state = sm3_pkg::S_PAD;
                    end
                end
            end

            sm3_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.capture = 1'b1;
                    n_fill      = '0;
                    n_pad       = 1'b0;
                    n_state     = sm3_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sm3_pkg::S_IDLE;
            end
        endcase
    end

    // digest beat stays until taken; a new capture may replace a taken beat
    always_comb begin
        if (cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // every compression starts from a window load
    a_round_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sm3_pkg::S_ROUND && $past(r_state) != sm3_pkg::S_ROUND)
            |-> $past(cmd.load))
        else $error("compression entered without loading the working registers");

    // the final padded block ends in the digest hand-off
    a_final_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sm3_pkg::S_ROUND && r_round == 6'd63 && r_pad && r_final)
            |=> r_state == sm3_pkg::S_DONE)
        else $error("final block did not lead to the digest");

    // a single padded block never runs past word 15
    a_one_block_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sm3_pkg::S_PAD && !r_two) |-> (r_pos <= 5'd15))
        else $error("padding position past the single block");

    // a last word starts padding
    a_last_to_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_last) |=> r_state == sm3_pkg::S_PAD)
        else $error("last word did not start padding");

endmodule

@@ hdl/sm3_dpath.sv @@
// sm3_dpath: block window with message expansion, round logic, chaining value
// depends on sm3_pkg

module sm3_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_data_word,
    input  sm3_pkg::t_dp_cmd    i_cmd,
    output logic [3:0][63:0]    o_digest
);

    logic [31:0] r_win [16];
    logic [31:0] r_v   [8];
    logic [63:0] r_len;
    logic [31:0] r_last_word;
    logic [31:0] r_tj;
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [3:0][63:0] r_digest;

    logic [31:0] exp_word;
    logic [31:0] pad_word;
    logic [31:0] win_in;
    logic [31:0] masked_last;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [31:0] n_a, n_c, n_e, n_g;

    // next expanded word: W[j+16] from the window W[j..j+15]
    assign exp_word = sm3_pkg::perm1(r_win[0] ^ r_win[7] ^ sm3_pkg::rotl32(r_win[13], 5'd15))
                      ^ sm3_pkg::rotl32(r_win[3], 5'd7) ^ r_win[10];

    // last word: keep the valid bytes and append the pad byte unless all four are valid
    always_comb begin
        case (i_cmd.byte_n)
            3'd0:    masked_last = sm3_pkg::PAD_MARK;
            3'd1:    masked_last = {i_data_word[31:24], sm3_pkg::PAD_BYTE, 16'h0000};
            3'd2:    masked_last = {i_data_word[31:16], sm3_pkg::PAD_BYTE, 8'h00};
            3'd3:    masked_last = {i_data_word[31:8], sm3_pkg::PAD_BYTE};
            default: masked_last = i_data_word;
        endcase
    end

    // padding word
    always_comb begin
        case (i_cmd.pad_sel)
            sm3_pkg::PAD_LAST:      pad_word = r_last_word;
            sm3_pkg::PAD_MARK_WORD: pad_word = sm3_pkg::PAD_MARK;
            sm3_pkg::PAD_LEN_HI:    pad_word = r_len[63:32];
            sm3_pkg::PAD_LEN_LO:    pad_word = r_len[31:0];
            default:                pad_word = '0;
        endcase
    end

    always_comb begin
        if (i_cmd.shift_in) begin
            win_in = i_data_word;
        end else if (i_cmd.pad_shift) begin
            win_in = pad_word;
        end else begin
            win_in = exp_word;
        end
    end

    // block window, shifts toward entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in || i_cmd.pad_shift || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= win_in;
        end
    end

    // message bit length and held last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.capture) begin
            r_len <= '0;
        end else if (i_cmd.shift_in) begin
            r_len <= r_len + 64'd32;
        end else if (i_cmd.latch_last) begin
            r_len <= r_len + {58'd0, i_cmd.byte_n, 3'b000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_last) begin
            r_last_word <= masked_last;
        end
    end

    // one compression round
    always_comb begin
        a12 = sm3_pkg::rotl32(r_a, 5'd12);
        ss1 = sm3_pkg::rotl32(a12 + r_e + r_tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (i_cmd.early) begin
            ff = r_a ^ r_b ^ r_c;
            gg = r_e ^ r_f ^ r_g;
        end else begin
            ff = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            gg = (r_e & r_f) | (~r_e & r_g);
        end
        tt1 = ff + r_d + ss2 + (r_win[0] ^ r_win[4]);
        tt2 = gg + r_h + ss1 + r_win[0];
        n_a = tt1;
        n_c = sm3_pkg::rotl32(r_b, 5'd9);
        n_e = sm3_pkg::perm0(tt2);
        n_g = sm3_pkg::rotl32(r_f, 5'd19);
    end

    // working registers and rotating round constant
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= r_v[0];
            r_b  <= r_v[1];
            r_c  <= r_v[2];
            r_d  <= r_v[3];
            r_e  <= r_v[4];
            r_f  <= r_v[5];
            r_g  <= r_v[6];
            r_h  <= r_v[7];
            r_tj <= sm3_pkg::T_LOW;
        end else if (i_cmd.round) begin
            r_a  <= n_a;
            r_b  <= r_a;
            r_c  <= n_c;
            r_d  <= r_c;
            r_e  <= n_e;
            r_f  <= r_e;
            r_g  <= n_g;
            r_h  <= r_g;
            r_tj <= i_cmd.t_switch ? sm3_pkg::T_HIGH_ROT : sm3_pkg::rotl32(r_tj, 5'd1);
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.capture) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= sm3_pkg::SM3_IV[i];
            end
        end else if (i_cmd.round_last) begin
            r_v[0] <= r_v[0] ^ n_a;
            r_v[1] <= r_v[1] ^ r_a;
            r_v[2] <= r_v[2] ^ n_c;
            r_v[3] <= r_v[3] ^ r_c;
            r_v[4] <= r_v[4] ^ n_e;
            r_v[5] <= r_v[5] ^ r_e;
            r_v[6] <= r_v[6] ^ n_g;
            r_v[7] <= r_v[7] ^ r_g;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < 4; i++) begin
                r_digest[i] <= {r_v[2*i], r_v[2*i+1]};
            end
        end
    end

    assign o_digest = r_digest;

endmodule

@@ hdl/sm3_hash_engine.sv @@
// sm3_hash_engine: streaming sm3 hash, message words in, 256-bit digest out
// depends on sm3_pkg, sm3_in_if, sm3_out_if, sm3_ctrl, sm3_dpath
//
//  channel   dir  payload                                   beat
//  i_msg     in   data_word[31:0] byte_count[2:0] is_last   one message word
//  o_digest  out  digest_part_0..3, 64 bits each            one digest
//
// a word that is not last only enters the block window; the sixteenth word of a
// block also starts its compression, one round per cycle in the shared round logic
// a last word adds padding and compression of the padded block, or of two padded
// blocks when the length spills into a second block, and then the move of the
// digest into the output register
// reset is synchronous, active low, and restores the initial chaining value
// words are refused during padding and compression and while a finished
// digest waits for the previous one to be taken

module sm3_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sm3_in_if.sink      i_msg,
    sm3_out_if.source   o_digest
);

    sm3_pkg::t_dp_cmd cmd;
    logic [3:0][63:0] digest;

    sm3_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_msg.valid),
        .i_is_last    (i_msg.is_last),
        .i_byte_count (i_msg.byte_count),
        .o_in_ready   (i_msg.ready),
        .o_out_valid  (o_digest.valid),
        .i_out_ready  (o_digest.ready),
        .o_cmd        (cmd)
    );

    sm3_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_word (i_msg.data_word),
        .i_cmd       (cmd),
        .o_digest    (digest)
    );

    assign o_digest.digest_part_0 = digest[0];
    assign o_digest.digest_part_1 = digest[1];
    assign o_digest.digest_part_2 = digest[2];
    assign o_digest.digest_part_3 = digest[3];

endmodule

@@ verif/sm3_digest_checker.sv @@
// sm3_digest_checker: scoreboard for the sm3 hash engine, predicts each digest
// from the accepted message words and compares it with the digest channel
// depends on nothing but the channel signals handed in by the testbench top

module sm3_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_word_valid,
    input  logic        i_word_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_is_last,
    input  logic        i_digest_valid,
    input  logic        i_digest_ready,
    input  logic [63:0] i_digest_part_0,
    input  logic [63:0] i_digest_part_1,
    input  logic [63:0] i_digest_part_2,
    input  logic [63:0] i_digest_part_3,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digests_checked
);

    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };
    localparam logic [31:0] ROUND_K_EARLY = 32'h79CC4519;
    localparam logic [31:0] ROUND_K_LATE  = 32'h7A879D8A;
    localparam logic [31:0] END_MARKER    = 32'h80000000;
    localparam int          MAX_REPORTS   = 10;

    // predicted engine state
    logic [31:0]  hash_state [8];
    logic [31:0]  msg_words [16];
    int           word_fill;
    logic [63:0]  bit_len;
    logic [255:0] digest_q [$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int r);
        int s;
        s = r % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] mix0(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    // one sm3 compression folded into hash_state
    function automatic void fold_block(input logic [31:0] blk [16]);
        logic [31:0] w [68];
        logic [31:0] wx [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = blk[j];
        for (j = 16; j < 68; j++)
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
        for (j = 0; j < 64; j++)
            wx[j] = w[j] ^ w[j+4];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (j = 0; j < 64; j++) begin
            t   = rol((j < 16) ? ROUND_K_EARLY : ROUND_K_LATE, j);
            a12 = rol(a, 12);
            ss1 = rol(a12 + e + t, 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end else begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + wx[j];
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol(b, 9); b = a; a = tt1;
            h = g; g = rol(f, 19); f = e; e = mix0(tt2);
        end
        hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
        hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
    endfunction

    function automatic void restart_message();
        int k;
        for (k = 0; k < 8; k++)
            hash_state[k] = INIT_CHAIN[k];
        word_fill = 0;
        bit_len   = '0;
    endfunction

    // one accepted word beat; a last word pads, finishes and queues the digest
    function automatic void absorb_word(input logic [31:0] data, input logic [2:0] cnt,
                                        input logic last);
        logic [31:0] pad [32];
        logic [31:0] lo [16];
        logic [31:0] hi [16];
        logic [31:0] mask;
        logic [63:0] bits;
        int n, rem, k;
        bit two_blocks;
        if (!last) begin
            msg_words[word_fill] = data;
            word_fill++;
            bit_len += 64'd32;
            if (word_fill == 16) begin
                fold_block(msg_words);
                word_fill = 0;
            end
        end else begin
            // counts above four saturate
            n = (cnt > 3'd4) ? 4 : int'(cnt);
            for (k = 0; k < 32; k++)
                pad[k] = '0;
            for (k = 0; k < word_fill; k++)
                pad[k] = msg_words[k];
            if (n == 4) begin
                pad[word_fill]     = data;
                pad[word_fill + 1] = END_MARKER;
            end else begin
                // invalid trailing bytes masked, marker byte right after the valid ones
                mask = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
                pad[word_fill] = (data & mask) | (END_MARKER >> (8 * n));
            end
            bits = bit_len + 64'(8 * n);
            rem  = word_fill * 4 + n;
            two_blocks = (rem + 9 > 64);
            if (!two_blocks) begin
                pad[14] = bits[63:32];
                pad[15] = bits[31:0];
            end else begin
                pad[30] = bits[63:32];
                pad[31] = bits[31:0];
            end
            for (k = 0; k < 16; k++) begin
                lo[k] = pad[k];
                hi[k] = pad[k + 16];
            end
            fold_block(lo);
            if (two_blocks)
                fold_block(hi);
            digest_q.insert(digest_q.size(),
                            {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                             hash_state[4], hash_state[5], hash_state[6], hash_state[7]});
            restart_message();
        end
    endfunction

    task automatic note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS)
            $display("mismatch: %s", what);
    endtask

    // compare one digest beat field by field with the oldest prediction
    task automatic check_digest(input logic [255:0] seen);
        logic [255:0] want;
        int k;
        if (digest_q.size() == 0) begin
            note_failure($sformatf("digest %h with nothing expected", seen));
        end else begin
            want = digest_q.pop_front();
            for (k = 0; k < 4; k++) begin
                if (seen[255 - 64 * k -: 64] !== want[255 - 64 * k -: 64])
                    note_failure($sformatf("digest %0d part_%0d expected %h got %h",
                                           o_digests_checked, k,
                                           want[255 - 64 * k -: 64],
                                           seen[255 - 64 * k -: 64]));
            end
        end
        o_digests_checked++;
    endtask

    // sample both channels at the clock edge; counters clear during reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
            o_fail_count      = 0;
            o_digests_checked = 0;
        end else begin
            if (i_word_valid && i_word_ready)
                absorb_word(i_data_word, i_byte_count, i_is_last);
            if (i_digest_valid && i_digest_ready)
                check_digest({i_digest_part_0, i_digest_part_1,
                              i_digest_part_2, i_digest_part_3});
        end
        o_pending = digest_q.size();
    end

endmodule

@@ verif/tb_sm3_hash_engine.sv @@
// tb_sm3_hash_engine: testbench top, drives message words with random gaps and
// digest backpressure, and gives the verdict from sm3_digest_checker
// depends on sm3_in_if, sm3_out_if, sm3_hash_engine and sm3_digest_checker

module tb_sm3_hash_engine;

    localparam int WORD_TARGET = 1150;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 300;
    localparam int MAX_GAP     = 5;

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   cycle_count = 0;
    int   words_sent;
    int   messages_sent;
    int   fail_count;
    int   pending;
    int   digests_checked;

    sm3_in_if  msg_if ();
    sm3_out_if dig_if ();

    sm3_hash_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if),
        .o_digest (dig_if)
    );

    sm3_digest_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_word_valid      (msg_if.valid),
        .i_word_ready      (msg_if.ready),
        .i_data_word       (msg_if.data_word),
        .i_byte_count      (msg_if.byte_count),
        .i_is_last         (msg_if.is_last),
        .i_digest_valid    (dig_if.valid),
        .i_digest_ready    (dig_if.ready),
        .i_digest_part_0   (dig_if.digest_part_0),
        .i_digest_part_1   (dig_if.digest_part_1),
        .i_digest_part_2   (dig_if.digest_part_2),
        .i_digest_part_3   (dig_if.digest_part_3),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_digests_checked (digests_checked)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog: run stalled after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one word beat: optional gap, then hold valid until the engine takes it
    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_if.valid      <= 1'b1;
        msg_if.data_word  <= data;
        msg_if.byte_count <= cnt;
        msg_if.is_last    <= last;
        do @(posedge i_clk); while (!msg_if.ready);
        words_sent++;
        if (last)
            messages_sent++;
    endtask

    // random content; the ignored count on body words still toggles
    task automatic send_message(input int body_words);
        int k;
        for (k = 0; k < body_words; k++)
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // digest sink with random backpressure per beat
    initial begin
        int stall;
        dig_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                dig_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            dig_if.ready <= 1'b1;
            do @(posedge i_clk); while (!dig_if.valid);
        end
    end

    // stimulus and verdict
    initial begin
        int k, pick, body;
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        words_sent        = 0;
        messages_sent     = 0;
        msg_if.valid      = 1'b0;
        msg_if.data_word  = '0;
        msg_if.byte_count = '0;
        msg_if.is_last    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, data ignored
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);
        // "abc"
        send_word(32'h61626300, 3'd3, 1'b1);
        // byte count extremes, masking and saturation
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'hFFFFFFFF, 3'd2, 1'b1);
        send_word(32'hA5A5A5A5, 3'd5, 1'b1);
        send_word(32'h00000000, 3'd6, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        // length spills into a second padding block
        for (k = 0; k < 15; k++)
            send_word(32'hFFFFFFFF, 3'(k % 8), 1'b0);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);

        // random messages, lengths bunched around the block boundaries
        while (words_sent < WORD_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                body = $urandom_range(0, 12);
            else if (pick < 8)
                body = 16 * $urandom_range(0, 2) + $urandom_range(12, 16);
            else
                body = $urandom_range(0, 80);
            send_message(body);
        end
        msg_if.valid <= 1'b0;
        calm = 1'b0;

        // drain
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("summary: %0d words in %0d messages, %0d digests compared, %0d failures",
                 words_sent, messages_sent, digests_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
